// File: rtl/pqem_pkg.sv
// Shared types and constants for the extract-max priority queue.
// Used by pqem_cell, pqem_ctrl and priority_queue_extract_max_core; no dependencies.
`timescale 1ns / 1ps

package pqem_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int PRI_W    = 8;
    localparam int PAY_W    = 32;

    localparam logic FUNC_INSERT  = 1'b0;
    localparam logic FUNC_EXTRACT = 1'b1;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_EXTRACTED = 2'd1;
    localparam logic [1:0] ST_NONE      = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [PRI_W-1:0] pri;
        logic [PAY_W-1:0] pay;
    } entry_t;

    typedef struct packed {
        logic             func;
        logic [PRI_W-1:0] item_priority;
        logic [PAY_W-1:0] item_payload;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [PRI_W-1:0] out_priority;
        logic [PAY_W-1:0] out_payload;
    } result_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic             ins;
        logic [OCC_W-1:0] occ;
        entry_t           ins_entry;
        logic             go;
    } cell_ctl_t;

endpackage

// File: rtl/pqem_cell.sv
// One queue slot: holds an entry, forwards the best candidate toward slot 0,
// and shifts down when the removal token passes. Depends on pqem_pkg.
`timescale 1ns / 1ps

module pqem_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [pqem_pkg::IDX_W-1:0]  idx,
    input  pqem_pkg::cell_ctl_t         ctl,
    input  pqem_pkg::entry_t            up_entry,
    input  pqem_pkg::entry_t            cin,
    input  logic                        tok_in,
    input  logic                        shift_in,
    output pqem_pkg::entry_t            entry_out,
    output pqem_pkg::entry_t            cout,
    output logic                        tok_out,
    output logic                        shift_out
);

    pqem_pkg::entry_t entry_reg;
    pqem_pkg::entry_t cout_reg;
    logic             flag_reg;
    logic             tok_reg;
    logic             shift_reg;

    logic [pqem_pkg::OCC_W-1:0] my_pos;
    logic                       occupied;
    logic                       beats;
    logic                       mine;
    logic                       wr_here;

    assign my_pos   = pqem_pkg::OCC_W'(idx);
    assign occupied = my_pos < ctl.occ;
    // Ties go to the lower slot, so an equal priority takes over the candidate
    assign beats    = occupied && (entry_reg.pri != '0) && (entry_reg.pri >= cin.pri);
    assign mine     = shift_in | flag_reg;
    assign wr_here  = ctl.ins && (my_pos == ctl.occ);

    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            entry_reg <= ctl.ins_entry;
        end
        else if (tok_in && mine)
        begin
            entry_reg <= up_entry;
        end
        cout_reg <= beats ? entry_reg : cin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg  <= 1'b0;
            tok_reg   <= 1'b0;
            shift_reg <= 1'b0;
        end
        else
        begin
            flag_reg  <= beats;
            tok_reg   <= tok_in;
            shift_reg <= tok_in & mine;
        end
    end

    assign entry_out = entry_reg;
    assign cout      = cout_reg;
    assign tok_out   = tok_reg;
    assign shift_out = shift_reg;

endmodule

// File: rtl/pqem_ctrl.sv
// Sequencer for the extract-max queue: occupancy, scan wait, removal wave, result.
// Depends on pqem_pkg.
`timescale 1ns / 1ps

module pqem_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  pqem_pkg::cmd_t        cmd,
    input  pqem_pkg::entry_t      head,
    input  logic                  last_tok,
    output logic                  busy,
    output logic                  done,
    output pqem_pkg::result_t     result,
    output pqem_pkg::cell_ctl_t   ctl
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [pqem_pkg::OCC_W-1:0] occ_reg, occ_next;
    logic [pqem_pkg::OCC_W-1:0] cnt_reg, cnt_next;
    logic                       done_reg, done_next;
    pqem_pkg::result_t          result_reg, result_next;

    logic full;
    logic accept;
    logic scan_end;

    assign full     = occ_reg == pqem_pkg::OCC_W'(pqem_pkg::CAPACITY);
    assign accept   = (state_reg == S_IDLE) && start;
    assign scan_end = (state_reg == S_SCAN)
                   && (cnt_reg == pqem_pkg::OCC_W'(pqem_pkg::CAPACITY));

    always_comb
    begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.func == pqem_pkg::FUNC_INSERT)
                    begin
                        done_next                = 1'b1;
                        result_next.out_priority = '0;
                        result_next.out_payload  = '0;
                        if (full)
                        begin
                            result_next.status = pqem_pkg::ST_FULL;
                        end
                        else
                        begin
                            result_next.status = pqem_pkg::ST_INSERTED;
                            occ_next           = occ_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        cnt_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (scan_end)
                begin
                    done_next = 1'b1;
                    if (head.pri == '0)
                    begin
                        result_next.status       = pqem_pkg::ST_NONE;
                        result_next.out_priority = '0;
                        result_next.out_payload  = '0;
                        state_next               = S_IDLE;
                    end
                    else
                    begin
                        result_next.status       = pqem_pkg::ST_EXTRACTED;
                        result_next.out_priority = head.pri;
                        result_next.out_payload  = head.pay;
                        state_next               = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                if (last_tok)
                begin
                    occ_next   = occ_reg - 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

    assign ctl.ins           = accept && (cmd.func == pqem_pkg::FUNC_INSERT) && !full;
    assign ctl.occ           = occ_reg;
    assign ctl.ins_entry.pri = cmd.item_priority;
    assign ctl.ins_entry.pay = cmd.item_payload;
    assign ctl.go            = scan_end && (head.pri != '0);

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= pqem_pkg::OCC_W'(pqem_pkg::CAPACITY))
        else $error("occupancy above capacity");

    a_occ_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && last_tok) |=> (occ_reg == $past(occ_reg) - 1'b1))
        else $error("removal did not decrement occupancy");

endmodule

// File: rtl/priority_queue_extract_max_core.sv
// Top level of the extract-max priority queue: controller plus a chain of slot cells.
// Depends on pqem_pkg, pqem_cell and pqem_ctrl.
`timescale 1ns / 1ps

// Bounded priority queue of CAPACITY entries kept in arrival order. Issue a
// command by raising start while busy is low; the command transfers at that
// clock edge. func selects insert (append priority and payload) or extract
// (remove the first entry holding the strictly greatest nonzero priority).
// Every command produces exactly one result, shown on result for a single
// cycle with done high; the receiver cannot stall, so capture it then.
// An insert's result appears the next cycle and busy never rises, so inserts
// may issue every cycle. An extract's result waits on the scan of the
// best-candidate chain, which moves one slot per cycle toward slot 0; when an
// entry is removed, a removal token then walks the chain one slot per cycle
// closing the gap, so busy holds until the token leaves the top of the chain
// (only until the result when nothing is eligible).
// Status codes: inserted, extracted, nothing eligible, full (insert dropped).
module priority_queue_extract_max_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  pqem_pkg::cmd_t       cmd,
    output logic                 busy,
    output logic                 done,
    output pqem_pkg::result_t    result
);

    pqem_pkg::cell_ctl_t ctl;

    // Chain links: index g feeds cell g from cell g + 1 (carry, entry) or from
    // cell g - 1 (token, shift); the far ends are tied off.
    pqem_pkg::entry_t           ent [0:pqem_pkg::CAPACITY];
    pqem_pkg::entry_t           cy  [0:pqem_pkg::CAPACITY];
    logic [pqem_pkg::CAPACITY:0] tok;
    logic [pqem_pkg::CAPACITY:0] shf;

    assign ent[pqem_pkg::CAPACITY] = '0;
    assign cy[pqem_pkg::CAPACITY]  = '0;
    // Launch the removal token at slot 0; nothing below slot 0 is removed
    assign tok[0] = ctl.go;
    assign shf[0] = 1'b0;

    pqem_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .head     (cy[0]),
        .last_tok (tok[pqem_pkg::CAPACITY]),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .ctl      (ctl)
    );

    for (genvar g = 0; g < pqem_pkg::CAPACITY; g++)
    begin : g_cell
        pqem_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (pqem_pkg::IDX_W'(g)),
            .ctl       (ctl),
            .up_entry  (ent[g+1]),
            .cin       (cy[g+1]),
            .tok_in    (tok[g]),
            .shift_in  (shf[g]),
            .entry_out (ent[g]),
            .cout      (cy[g]),
            .tok_out   (tok[g+1]),
            .shift_out (shf[g+1])
        );
    end

    // Only one removal wave may be in flight
    a_tok_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok))
        else $error("more than one removal token in the chain");

    // A new wave starts only on an empty chain
    a_go_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.go |-> (tok[pqem_pkg::CAPACITY:1] == '0))
        else $error("removal launched while a wave is in flight");

    // When the token leaves the chain, the shift must have reached the top slot
    a_shift_reach: assert property (@(posedge clk) disable iff (!rst_n)
        tok[pqem_pkg::CAPACITY] |-> shf[pqem_pkg::CAPACITY])
        else $error("removal wave ended without finding the selected slot");

endmodule

// File: sim/tb_priority_queue_extract_max_core.sv
// Self-checking testbench for priority_queue_extract_max_core:
// directed table, then random traffic.
// Depends on pqem_pkg and the core; predicts every result with its own copy of the queue.
`timescale 1ns / 1ps

module tb_priority_queue_extract_max_core;

    localparam int CLK_HALF   = 4;
    localparam int RAND_ITEMS = 600;
    localparam int DRAIN_WAIT = 2 * pqem_pkg::CAPACITY + 8;   // one full extract plus margin
    localparam int LIMIT      = 400000;             // cycles, far above the slowest run

    // One row of the directed part. Rows with want_typed carry a result known
    // by inspection; the rest are checked against the queue model.
    typedef struct {
        pqem_pkg::cmd_t    c;
        int                reps;    // repeat count, payload advances by one per repeat
        bit                want_typed;
        pqem_pkg::result_t want;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    pqem_pkg::cmd_t    cmd;
    logic              busy;
    logic              done;
    pqem_pkg::result_t result;

    // Queue model: entries in arrival order, oldest at index 0
    logic [pqem_pkg::PRI_W-1:0] queue_pri [pqem_pkg::CAPACITY];
    logic [pqem_pkg::PAY_W-1:0] queue_pay [pqem_pkg::CAPACITY];
    int                         queue_occ;

    pqem_pkg::result_t expected_results [$];
    int unsigned       mismatch_count;
    int unsigned       cycle_count;

    priority_queue_extract_max_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // Apply one command to the queue model and return the result it gives.
    // Extract picks the first entry holding the greatest nonzero priority, so
    // ties go to the oldest; the later entries then close the gap.
    function automatic pqem_pkg::result_t queue_apply(input pqem_pkg::cmd_t c);
        pqem_pkg::result_t          r;
        int                         best;
        logic [pqem_pkg::PRI_W-1:0] top_pri;
        r       = '0;
        best    = -1;
        top_pri = '0;
        if (c.func == pqem_pkg::FUNC_INSERT)
        begin
            if (queue_occ >= pqem_pkg::CAPACITY)
            begin
                r.status = pqem_pkg::ST_FULL;
            end
            else
            begin
                queue_pri[queue_occ] = c.item_priority;
                queue_pay[queue_occ] = c.item_payload;
                queue_occ++;
                r.status = pqem_pkg::ST_INSERTED;
            end
        end
        else
        begin
            for (int i = 0; i < queue_occ; i++)
            begin
                if (queue_pri[i] > top_pri)
                begin
                    top_pri = queue_pri[i];
                    best    = i;
                end
            end
            if (best < 0)
            begin
                r.status = pqem_pkg::ST_NONE;
            end
            else
            begin
                r.status       = pqem_pkg::ST_EXTRACTED;
                r.out_priority = queue_pri[best];
                r.out_payload  = queue_pay[best];
                for (int i = best; i + 1 < queue_occ; i++)
                begin
                    queue_pri[i] = queue_pri[i + 1];
                    queue_pay[i] = queue_pay[i + 1];
                end
                queue_occ--;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Present a command and hold it until it transfers (start high, busy low
    // at the edge), then log the expected result. Busy and start are sampled
    // at the edge before any update of that step lands.
    task automatic issue_cmd(input pqem_pkg::cmd_t c, input bit want_typed,
                             input pqem_pkg::result_t want);
        pqem_pkg::result_t predicted;
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predicted = queue_apply(c);
        expected_results.push_back(want_typed ? want : predicted);
    endtask

    // Drop start for a random number of cycles: mostly none or short, a few long
    task automatic idle_gap();
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Result checker: every done strobe must match the oldest expectation
    always @(posedge clk)
    begin
        pqem_pkg::result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result status=%0d pri=%0h pay=%0h",
                                          result.status, result.out_priority,
                                          result.out_payload));
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.status !== want.status ||
                    result.out_priority !== want.out_priority ||
                    result.out_payload !== want.out_payload)
                    report_mismatch($sformatf(
                        "expected status=%0d pri=%0h pay=%0h, got status=%0d pri=%0h pay=%0h",
                        want.status, want.out_priority, want.out_payload,
                        result.status, result.out_priority, result.out_payload));
            end
        end
    end

    // Watchdog: end a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("tb_priority_queue_extract_max_core: FAIL");
            $finish;
        end
    end

    initial
    begin
        dir_row_t       dir_rows [15];
        pqem_pkg::cmd_t c;
        int             ins_pct;
        int             pick;

        rst_n          = 1'b0;
        start          = 1'b0;
        cmd            = '0;
        queue_occ      = 0;
        mismatch_count = 0;
        cycle_count    = 0;

        // Empty queue, then the zero-priority case, ties, the full table, and
        // extract with its ignored fields set high.
        dir_rows[0]  = '{'{pqem_pkg::FUNC_EXTRACT, 8'hFF, 32'hFFFF_FFFF}, 1, 1'b1,
                         '{pqem_pkg::ST_NONE, 8'h00, 32'h0}};
        dir_rows[1]  = '{'{pqem_pkg::FUNC_INSERT, 8'h00, 32'h0000_0000}, 1, 1'b1,
                         '{pqem_pkg::ST_INSERTED, 8'h00, 32'h0}};
        dir_rows[2]  = '{'{pqem_pkg::FUNC_EXTRACT, 8'h00, 32'h0}, 1, 1'b1,
                         '{pqem_pkg::ST_NONE, 8'h00, 32'h0}};
        dir_rows[3]  = '{'{pqem_pkg::FUNC_INSERT, 8'hFF, 32'hFFFF_FFFF}, 1, 1'b1,
                         '{pqem_pkg::ST_INSERTED, 8'h00, 32'h0}};
        dir_rows[4]  = '{'{pqem_pkg::FUNC_INSERT, 8'hFF, 32'h1234_5678}, 1, 1'b1,
                         '{pqem_pkg::ST_INSERTED, 8'h00, 32'h0}};
        dir_rows[5]  = '{'{pqem_pkg::FUNC_INSERT, 8'h01, 32'h0000_0001}, 1, 1'b1,
                         '{pqem_pkg::ST_INSERTED, 8'h00, 32'h0}};
        dir_rows[6]  = '{'{pqem_pkg::FUNC_EXTRACT, 8'h00, 32'h0}, 1, 1'b1,
                         '{pqem_pkg::ST_EXTRACTED, 8'hFF, 32'hFFFF_FFFF}};
        dir_rows[7]  = '{'{pqem_pkg::FUNC_EXTRACT, 8'h00, 32'h0}, 1, 1'b1,
                         '{pqem_pkg::ST_EXTRACTED, 8'hFF, 32'h1234_5678}};
        dir_rows[8]  = '{'{pqem_pkg::FUNC_EXTRACT, 8'h00, 32'h0}, 1, 1'b1,
                         '{pqem_pkg::ST_EXTRACTED, 8'h01, 32'h0000_0001}};
        dir_rows[9]  = '{'{pqem_pkg::FUNC_EXTRACT, 8'h00, 32'h0}, 1, 1'b1,
                         '{pqem_pkg::ST_NONE, 8'h00, 32'h0}};
        dir_rows[10] = '{'{pqem_pkg::FUNC_INSERT, 8'h07, 32'hA5A5_0000},
                         pqem_pkg::CAPACITY - 1, 1'b1,
                         '{pqem_pkg::ST_INSERTED, 8'h00, 32'h0}};
        dir_rows[11] = '{'{pqem_pkg::FUNC_INSERT, 8'hC8, 32'hDEAD_BEEF}, 1, 1'b1,
                         '{pqem_pkg::ST_FULL, 8'h00, 32'h0}};
        dir_rows[12] = '{'{pqem_pkg::FUNC_EXTRACT, 8'h00, 32'h0}, 3, 1'b0, '0};
        dir_rows[13] = '{'{pqem_pkg::FUNC_INSERT, 8'h80, 32'h8000_0000}, 1, 1'b1,
                         '{pqem_pkg::ST_INSERTED, 8'h00, 32'h0}};
        dir_rows[14] = '{'{pqem_pkg::FUNC_EXTRACT, 8'h00, 32'h0}, 1, 1'b1,
                         '{pqem_pkg::ST_EXTRACTED, 8'h80, 32'h8000_0000}};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Walk the directed table
        foreach (dir_rows[r])
        begin
            for (int k = 0; k < dir_rows[r].reps; k++)
            begin
                c              = dir_rows[r].c;
                c.item_payload = c.item_payload + k;
                issue_cmd(c, dir_rows[r].want_typed, dir_rows[r].want);
                idle_gap();
            end
        end

        // Random traffic. Vary the insert share every 40 transfers so the
        // queue swings between empty and full; narrow priorities force ties.
        ins_pct = 50;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       ins_pct = 25;
                    1:       ins_pct = 50;
                    2:       ins_pct = 75;
                    default: ins_pct = 90;
                endcase
            end
            c.func = ($urandom_range(0, 99) < ins_pct) ? pqem_pkg::FUNC_INSERT
                                                        : pqem_pkg::FUNC_EXTRACT;
            pick   = $urandom_range(0, 9);
            if (pick == 0)
                c.item_priority = '0;
            else if (pick == 1)
                c.item_priority = '1;
            else if (pick < 6)
                c.item_priority = pqem_pkg::PRI_W'($urandom_range(1, 4));
            else
                c.item_priority = pqem_pkg::PRI_W'($urandom_range(0, 255));
            c.item_payload = $urandom();
            issue_cmd(c, 1'b0, '0);
            idle_gap();
        end
        start <= 1'b0;

        // Drain: wait for every expected result, then for one extract's worth
        // of cycles so a stray strobe still gets caught.
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results still outstanding at end of run");

        if (mismatch_count == 0)
            $display("tb_priority_queue_extract_max_core: PASS");
        else
            $display("tb_priority_queue_extract_max_core: FAIL");
        $finish;
    end

endmodule
